/* design/descending_table_binary_search_macros.svh */
// assertion macros for the descending table binary search block
// no dependencies; included by the top level
`ifndef DESCENDING_TABLE_BINARY_SEARCH_MACROS_SVH
`define DESCENDING_TABLE_BINARY_SEARCH_MACROS_SVH

`ifndef SYNTHESIS
`define DTBS_ASSERT_SAME(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (expr)) \
        else $error("dtbs check failed");
`define DTBS_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (expr)) \
        else $error("dtbs check failed");
`else
`define DTBS_ASSERT_SAME(label, clk, rst_n, cond, expr)
`define DTBS_ASSERT_NEXT(label, clk, rst_n, cond, expr)
`endif

`endif

/* design/dtbs_pkg.sv */
// shared types and constants of the descending table binary search block
// no dependencies
package dtbs_pkg;

    localparam int TABLE_DEPTH   = 1024;
    localparam int IDX_W         = $clog2(TABLE_DEPTH);
    localparam int PTR_W         = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_W         = 16;
    localparam int ENTRY_INDEX_W = 10;
    localparam int COUNT_W       = 11;
    localparam int PROBE_W       = 4;

    typedef logic signed [KEY_W-1:0] t_key;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
        t_key             wdata;
    } t_mem_req;

    typedef struct packed {
        logic                     valid;
        logic                     found;
        logic [ENTRY_INDEX_W-1:0] index;
        logic [PROBE_W-1:0]       probes;
    } t_result;

endpackage

/* design/dtbs_key_mem.sv */
// key table storage, one write or read port, registered read data
// depends on dtbs_pkg
module dtbs_key_mem (
    input  logic              i_clk,
    input  dtbs_pkg::t_mem_req i_req,
    output dtbs_pkg::t_key     o_rd_data
);
    import dtbs_pkg::*;

    t_key r_mem [TABLE_DEPTH];
    t_key r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        r_rd_data <= r_mem[i_req.addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* design/dtbs_search_seq.sv */
// binary search sequencer: midpoint, compare and bound update over the key table
// depends on dtbs_pkg
module dtbs_search_seq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  dtbs_pkg::t_key              i_search_key,
    input  logic [dtbs_pkg::PTR_W-1:0]  i_entry_count,
    input  dtbs_pkg::t_key              i_rd_data,
    output logic [dtbs_pkg::IDX_W-1:0]  o_rd_addr,
    output logic                        o_busy,
    output dtbs_pkg::t_result           o_result
);
    import dtbs_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROBE,
        S_CMP
    } t_state;

    t_state             r_state;
    logic [PTR_W-1:0]   r_lo;
    logic [PTR_W-1:0]   r_hi_excl;
    logic [IDX_W-1:0]   r_mid;
    logic [PROBE_W-1:0] r_probes;
    t_key               r_key;
    t_result            r_result;
    logic [PTR_W:0]     n_sum;
    logic [IDX_W-1:0]   n_mid;
    logic [PROBE_W-1:0] n_probes;

    assign n_sum    = {1'b0, r_lo} + {1'b0, r_hi_excl} - (PTR_W+1)'(1);
    assign n_mid    = IDX_W'(n_sum >> 1);
    assign n_probes = (r_probes == {PROBE_W{1'b1}}) ? r_probes : r_probes + PROBE_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_result.valid <= 1'b0;
        end else begin
            r_result.valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_lo      <= '0;
                        r_hi_excl <= i_entry_count;
                        r_probes  <= '0;
                        r_key     <= i_search_key;
                        r_state   <= S_PROBE;
                    end
                end
                S_PROBE: begin
                    if (r_lo < r_hi_excl) begin
                        r_mid   <= n_mid;
                        r_state <= S_CMP;
                    end else begin
                        r_result.valid  <= 1'b1;
                        r_result.found  <= 1'b0;
                        r_result.index  <= '0;
                        r_result.probes <= r_probes;
                        r_state         <= S_IDLE;
                    end
                end
                S_CMP: begin
                    r_probes <= n_probes;
                    if (r_key == i_rd_data) begin
                        r_result.valid  <= 1'b1;
                        r_result.found  <= 1'b1;
                        r_result.index  <= ENTRY_INDEX_W'(r_mid);
                        r_result.probes <= n_probes;
                        r_state         <= S_IDLE;
                    end else begin
                        if (r_key > i_rd_data) begin
                            r_hi_excl <= PTR_W'(r_mid);
                        end else begin
                            r_lo <= PTR_W'(r_mid) + PTR_W'(1);
                        end
                        r_state <= S_PROBE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rd_addr = n_mid;
    assign o_busy    = (r_state != S_IDLE);
    assign o_result  = r_result;

endmodule

/* design/descending_table_binary_search.sv */
// Binary search over a table of signed 16-bit keys kept in descending order.
// A write item (op 0) stores one key in the cycle it is taken and never raises
// busy. For each probe a search item (op 1) passes a probe state that reads
// the table at the midpoint and a compare state that compares and moves a
// bound; a miss closes in a final probe state, which then ends the search.
// The table has a single port, shared by writes and search reads.
// The result is shown on o_result_valid for one cycle and cannot be held off.
// The table has no reset; no clearing pass runs.
// depends on dtbs_pkg, dtbs_key_mem, dtbs_search_seq and the macros header
`include "descending_table_binary_search_macros.svh"

module descending_table_binary_search (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic                                   i_op,
    input  logic [dtbs_pkg::ENTRY_INDEX_W-1:0]     i_entry_index,
    input  logic signed [dtbs_pkg::KEY_W-1:0]      i_entry_value,
    input  logic signed [dtbs_pkg::KEY_W-1:0]      i_search_key,
    input  logic                                   i_cfg_we,
    input  logic [dtbs_pkg::COUNT_W-1:0]           i_cfg_wdata,
    output logic                                   o_result_valid,
    output logic                                   o_found,
    output logic [dtbs_pkg::ENTRY_INDEX_W-1:0]     o_found_index,
    output logic [dtbs_pkg::PROBE_W-1:0]           o_probe_count
);
    import dtbs_pkg::*;

    logic [COUNT_W-1:0] r_entry_count;
    logic [PTR_W-1:0]   n_count;
    logic               n_accept;
    logic               n_search;
    logic               n_busy;
    logic [IDX_W-1:0]   n_rd_addr;
    t_key               n_rd_data;
    t_mem_req           n_req;
    t_result            n_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
        end else if (i_cfg_we) begin
            r_entry_count <= i_cfg_wdata;
        end
    end

    always_comb begin
        if (int'(r_entry_count) > TABLE_DEPTH) begin
            n_count = PTR_W'(TABLE_DEPTH);
        end else begin
            n_count = PTR_W'(r_entry_count);
        end
    end

    assign n_accept = start && !n_busy;
    assign n_search = n_accept && (i_op == OP_SEARCH);

    always_comb begin
        n_req.we    = n_accept && (i_op == OP_WRITE) && (int'(i_entry_index) < TABLE_DEPTH);
        n_req.addr  = n_req.we ? IDX_W'(i_entry_index) : n_rd_addr;
        n_req.wdata = i_entry_value;
    end

    dtbs_key_mem u_key_mem (
        .i_clk     (i_clk),
        .i_req     (n_req),
        .o_rd_data (n_rd_data)
    );

    dtbs_search_seq u_search_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (n_search),
        .i_search_key  (i_search_key),
        .i_entry_count (n_count),
        .i_rd_data     (n_rd_data),
        .o_rd_addr     (n_rd_addr),
        .o_busy        (n_busy),
        .o_result      (n_result)
    );

    assign busy           = n_busy;
    assign o_result_valid = n_result.valid;
    assign o_found        = n_result.found;
    assign o_found_index  = n_result.index;
    assign o_probe_count  = n_result.probes;

    `DTBS_ASSERT_NEXT(a_search_goes_busy, i_clk, i_rst_n, n_search, busy)
    `DTBS_ASSERT_SAME(a_result_when_idle, i_clk, i_rst_n, o_result_valid, !busy)
    `DTBS_ASSERT_SAME(a_miss_index_zero, i_clk, i_rst_n, o_result_valid && !o_found, o_found_index == '0)
    `DTBS_ASSERT_SAME(a_hit_has_probe, i_clk, i_rst_n, o_result_valid && o_found, o_probe_count != '0)

endmodule

/* dv/tb_top.sv */
// testbench for descending_table_binary_search: table writes, sorted and unsorted
// searches over several table sizes, with results checked against a search model
// depends on dtbs_pkg and the descending_table_binary_search rtl

typedef struct packed {
    dtbs_pkg::t_key                           key;
    logic                                     found;
    logic [dtbs_pkg::ENTRY_INDEX_W-1:0]       index;
    logic [dtbs_pkg::PROBE_W-1:0]             probes;
} t_search_outcome;

class search_scoreboard;
    dtbs_pkg::t_key  key_table [dtbs_pkg::TABLE_DEPTH];
    bit              written [dtbs_pkg::TABLE_DEPTH];
    int              entry_count;
    t_search_outcome expected_q [$];
    int              mismatches;
    int              searches;
    int              hits;

    function void set_count(int count);
        entry_count = count;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    // binary search over the stored table, flagging probes of never-written entries
    function void walk(input dtbs_pkg::t_key key, output t_search_outcome res,
                       output bit safe);
        int lo;
        int hi;
        int mid;
        bit done;
        res = '0;
        res.key = key;
        safe = 1'b1;
        done = 1'b0;
        lo = 0;
        hi = ((entry_count > dtbs_pkg::TABLE_DEPTH) ? dtbs_pkg::TABLE_DEPTH : entry_count) - 1;
        while (!done && lo <= hi) begin
            mid = (lo + hi) / 2;
            if (!written[mid])
                safe = 1'b0;
            if (res.probes != 4'hf)
                res.probes = res.probes + 4'd1;
            if (key == key_table[mid]) begin
                res.found = 1'b1;
                res.index = mid[dtbs_pkg::ENTRY_INDEX_W-1:0];
                done = 1'b1;
            end else if (key > key_table[mid]) begin
                hi = mid - 1;
            end else begin
                lo = mid + 1;
            end
        end
    endfunction

    function bit probes_written(dtbs_pkg::t_key key);
        t_search_outcome res;
        bit safe;
        walk(key, res, safe);
        return safe;
    endfunction

    function void note_transfer(logic op, logic [dtbs_pkg::ENTRY_INDEX_W-1:0] idx,
                                dtbs_pkg::t_key val, dtbs_pkg::t_key key);
        t_search_outcome res;
        bit safe;
        if (op == dtbs_pkg::OP_WRITE) begin
            key_table[idx] = val;
            written[idx] = 1'b1;
        end else begin
            walk(key, res, safe);
            expected_q.push_back(res);
            searches++;
            if (res.found)
                hits++;
        end
    endfunction

    function void check_result(logic found, logic [dtbs_pkg::ENTRY_INDEX_W-1:0] idx,
                               logic [dtbs_pkg::PROBE_W-1:0] probes);
        t_search_outcome want;
        if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: found %0d index %0d probes %0d",
                         found, idx, probes);
            return;
        end
        want = expected_q.pop_front();
        if (want.found !== found || want.index !== idx || want.probes !== probes) begin
            mismatches++;
            if (mismatches <= 10)
                $display("key %0d: expected found %0d index %0d probes %0d, got %0d %0d %0d",
                         want.key, want.found, want.index, want.probes,
                         found, idx, probes);
        end
    endfunction
endclass

module tb_top;
    import dtbs_pkg::*;

    localparam int SETTLE_CYCLES = 30;
    localparam int STALL_LIMIT   = 2000;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic                     i_op = OP_WRITE;
    logic [ENTRY_INDEX_W-1:0] i_entry_index = '0;
    t_key                     i_entry_value = '0;
    t_key                     i_search_key = '0;
    logic                     i_cfg_we = 1'b0;
    logic [COUNT_W-1:0]       i_cfg_wdata = '0;
    logic                     o_result_valid;
    logic                     o_found;
    logic [ENTRY_INDEX_W-1:0] o_found_index;
    logic [PROBE_W-1:0]       o_probe_count;

    search_scoreboard sb;
    bit               burst;
    int               transfers;
    int               idle_cycles;
    int               phase_counts [14] = '{1, 2, 3, 5, 8, 16, 33, 64, 100, 300, 1024,
                                            2047, 0, 13};
    t_key             seed_keys [8] = '{16'sh7fff, 16'sd1000, 16'sd5, 16'sd0, -16'sd1,
                                        -16'sd200, -16'sd32767, 16'sh8000};
    t_key             probe_keys [8] = '{16'sh7fff, 16'sh8000, 16'sd0, -16'sd1, 16'sd2,
                                         16'sd1001, -16'sd32767, -16'sd200};
    t_key             key_pool [$];

    descending_table_binary_search uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_op           (i_op),
        .i_entry_index  (i_entry_index),
        .i_entry_value  (i_entry_value),
        .i_search_key   (i_search_key),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_result_valid (o_result_valid),
        .o_found        (o_found),
        .o_found_index  (o_found_index),
        .o_probe_count  (o_probe_count)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid)
            sb.check_result(o_found, o_found_index, o_probe_count);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_result_valid || i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL descending_table_binary_search");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_item(input logic op, input logic [ENTRY_INDEX_W-1:0] idx,
                             input t_key val, input t_key key);
        int unsigned gap;
        gap = burst ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_op          <= op;
        i_entry_index <= idx;
        i_entry_value <= val;
        i_search_key  <= key;
        do @(posedge i_clk); while (busy);
        sb.note_transfer(op, idx, val, key);
        transfers++;
    endtask

    task automatic write_entry(input logic [ENTRY_INDEX_W-1:0] idx, input t_key val);
        send_item(OP_WRITE, idx, val, t_key'($urandom));
    endtask

    task automatic run_search(input t_key key);
        send_item(OP_SEARCH, ENTRY_INDEX_W'($urandom), t_key'($urandom), key);
    endtask

    // only with no search in flight
    task automatic set_entry_count(input logic [COUNT_W-1:0] count);
        start <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= count;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_count(count);
    endtask

    initial begin
        int   n;
        int   nn;
        int   v;
        int   step;
        int   tgt;
        int   lo;
        int   hi;
        int   mid;
        bit   safe;
        t_key cand;
        sb = new;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table, then a small sorted table with both key extremes
        burst = 1'b0;
        run_search(16'sh7fff);
        run_search(16'sh8000);
        foreach (seed_keys[i])
            write_entry(i[ENTRY_INDEX_W-1:0], seed_keys[i]);
        write_entry(10'h3ff, 16'sh8000);
        set_entry_count(11'd8);
        foreach (probe_keys[i])
            run_search(probe_keys[i]);
        set_entry_count(11'd1);
        run_search(16'sh7fff);
        run_search(16'sd0);

        foreach (phase_counts[p]) begin
            n = phase_counts[p];
            nn = (n > TABLE_DEPTH) ? TABLE_DEPTH : n;
            burst = ($urandom_range(0, 2) == 0);
            set_entry_count(n[COUNT_W-1:0]);
            key_pool.delete();
            if (nn <= 64) begin
                // fill the whole live range, duplicates allowed
                v = 32767 - $urandom_range(0, 2000);
                for (int i = 0; i < nn; i++) begin
                    write_entry(i[ENTRY_INDEX_W-1:0], v[KEY_W-1:0]);
                    key_pool.push_back(v[KEY_W-1:0]);
                    v = v - $urandom_range(0, 60000 / nn);
                end
            end else begin
                // large table: write only the midpoints leading to a few targets
                step = 65535 / nn;
                for (int k = 0; k < 6; k++) begin
                    tgt = (k == 0) ? 0 : (k == 1) ? nn - 1 : $urandom_range(0, nn - 1);
                    lo = 0;
                    hi = nn - 1;
                    mid = -1;
                    while (mid != tgt) begin
                        mid = (lo + hi) / 2;
                        v = 32767 - step * mid;
                        write_entry(mid[ENTRY_INDEX_W-1:0], v[KEY_W-1:0]);
                        if (tgt < mid)
                            hi = mid - 1;
                        else
                            lo = mid + 1;
                    end
                    v = 32767 - step * tgt;
                    key_pool.push_back(v[KEY_W-1:0]);
                end
            end
            repeat (22) begin
                if ($urandom_range(0, 9) == 0)
                    write_entry(ENTRY_INDEX_W'($urandom), t_key'($urandom));
                safe = 1'b0;
                for (int t = 0; t < 8 && !safe; t++) begin
                    case ($urandom_range(0, 3))
                        0, 1: cand = (key_pool.size() == 0) ? t_key'($urandom)
                                   : key_pool[$urandom_range(0, key_pool.size() - 1)];
                        2: cand = (key_pool.size() == 0) ? t_key'($urandom)
                                : key_pool[$urandom_range(0, key_pool.size() - 1)]
                                  + ($urandom_range(0, 1) ? 16'sd1 : -16'sd1);
                        default: cand = t_key'($urandom);
                    endcase
                    safe = sb.probes_written(cand);
                end
                if (safe)
                    run_search(cand);
            end
        end

        start <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("covered %0d transfers (%0d searches, %0d hits) over %0d table sizes",
                 transfers, sb.searches, sb.hits, $size(phase_counts) + 2);
        $display("%0d mismatches", sb.mismatches);
        if (sb.mismatches == 0)
            $display("PASS descending_table_binary_search");
        else
            $display("FAIL descending_table_binary_search");
        $finish;
    end
endmodule

/* sim.f */
+incdir+design
design/dtbs_pkg.sv
design/dtbs_key_mem.sv
design/dtbs_search_seq.sv
design/descending_table_binary_search.sv
dv/tb_top.sv
